FILE: rtl/life_generation_column_stream_assert.svh
// Assertion helpers for the checker file of this block.
`ifndef LIFE_GENERATION_COLUMN_STREAM_ASSERT_SVH
`define LIFE_GENERATION_COLUMN_STREAM_ASSERT_SVH

// Checked on every clock edge outside reset.
`define LGCS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define LGCS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/lgcs_pkg.sv
package lgcs_pkg;

  // Width of a column on the stream ports.
  localparam int COLUMN_BITS = 64;

  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // Bits one cell shows to the cells of the rows above and below it.
  typedef struct packed {
    logic older;
    logic middle;
    logic current;
  } lgcs_nbr_t;

  // Column advance control, shared by every cell of the column.
  typedef struct packed {
    logic shift;
    logic clear;
  } lgcs_step_t;

  typedef struct packed {
    logic [COLUMN_BITS-1:0] cells;
    logic                   frame_end;
    logic                   run_last;
  } lgcs_result_t;

  // Results produced by one accepted column.
  typedef struct packed {
    logic         first_valid;
    lgcs_result_t first;
    logic         second_valid;
    lgcs_result_t second;
  } lgcs_req_t;

  function automatic logic [3:0] neighbor_count(input logic [7:0] bits);
    logic [3:0] sum;
    sum = 4'd0;
    for (int i = 0; i < 8; i++) begin
      sum = sum + {3'b000, bits[i]};
    end
    return sum;
  endfunction

  function automatic logic next_state(input logic alive, input logic [3:0] count);
    return (count == BIRTH_COUNT) || (alive && (count == SURVIVE_COUNT));
  endfunction

endpackage

FILE: rtl/life_generation_column_stream.sv
// One Conway Life generation (born on 3, survive on 2 or 3) over a grid whose
// outside is dead, streamed one column at a time from left to right.
// Slave side: each request carries one column of the current generation on
// s_tdata, with s_tlast set on the rightmost column of the grid.
// Master side: each request carries one column of the next generation on
// m_tdata; m_tlast marks the rightmost column of the new generation and
// m_tuser marks the last result caused by an input column.
// A column releases the new state of the column before it; the rightmost
// column releases two results, the first column of a frame none (unless it
// is also the rightmost). The first result of a column is registered as the
// column is taken. Throughput is one column per cycle while the receiver
// takes results and no second result waits; the second result of a rightmost
// column after another waits in a holding register behind the output
// register, and input is held off until it moves on. Rows at or above
// COLUMN_HEIGHT are ignored on input and are zero on output. Reset clears the
// held columns and both output registers; the next column starts a new frame.
// While the receiver stalls, the output holds steady and s_tready stays low.
module life_generation_column_stream #(
  parameter int COLUMN_HEIGHT = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [lgcs_pkg::COLUMN_BITS-1:0] s_tdata,  // [63:0] column_cells
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [lgcs_pkg::COLUMN_BITS-1:0] m_tdata,  // [63:0] next_cells
  output logic                             m_tlast,
  output logic                             m_tuser   // [0] run_last
);

  lgcs_pkg::lgcs_nbr_t        nbr [COLUMN_HEIGHT];
  logic [lgcs_pkg::COLUMN_BITS-1:0] mid_col;
  logic [lgcs_pkg::COLUMN_BITS-1:0] cur_col;
  lgcs_pkg::lgcs_step_t       step;
  lgcs_pkg::lgcs_req_t        req;
  lgcs_pkg::lgcs_result_t     res;
  logic                       take;
  logic                       seen;

  assign take       = s_tvalid && s_tready;
  assign step.shift = take && !s_tlast;
  assign step.clear = take && s_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (take) begin
      seen <= !s_tlast;
    end
  end

  for (genvar y = 0; y < COLUMN_HEIGHT; y++) begin : g_cell
    lgcs_pkg::lgcs_nbr_t below;
    lgcs_pkg::lgcs_nbr_t above;
    if (y == 0) begin : g_bottom
      assign below = '0;
    end else begin : g_below
      assign below = nbr[y-1];
    end
    if (y == COLUMN_HEIGHT - 1) begin : g_top
      assign above = '0;
    end else begin : g_above
      assign above = nbr[y+1];
    end
    lgcs_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .step     (step),
      .cur_bit  (s_tdata[y]),
      .below    (below),
      .above    (above),
      .here     (nbr[y]),
      .mid_next (mid_col[y]),
      .cur_next (cur_col[y])
    );
  end

  for (genvar y = COLUMN_HEIGHT; y < lgcs_pkg::COLUMN_BITS; y++) begin : g_unused_row
    assign mid_col[y] = 1'b0;
    assign cur_col[y] = 1'b0;
  end

  assign req.first_valid  = seen;
  assign req.first        = '{cells: mid_col, frame_end: 1'b0, run_last: !s_tlast};
  assign req.second_valid = s_tlast;
  assign req.second       = '{cells: cur_col, frame_end: 1'b1, run_last: 1'b1};

  lgcs_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .req       (req),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res)
  );

  assign m_tdata = res.cells;
  assign m_tlast = res.frame_end;
  assign m_tuser = res.run_last;

endmodule

FILE: rtl/lgcs_cell.sv
module lgcs_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  lgcs_pkg::lgcs_step_t step,
  input  logic                 cur_bit,
  input  lgcs_pkg::lgcs_nbr_t  below,
  input  lgcs_pkg::lgcs_nbr_t  above,
  output lgcs_pkg::lgcs_nbr_t  here,
  output logic                 mid_next,
  output logic                 cur_next
);

  logic older;
  logic middle;

  always_ff @(posedge clk) begin
    if (rst || step.clear) begin
      older  <= 1'b0;
      middle <= 1'b0;
    end else if (step.shift) begin
      older  <= middle;
      middle <= cur_bit;
    end
  end

  assign here = '{older: older, middle: middle, current: cur_bit};

  // The middle column sees older on its left and the incoming column on its right.
  // The incoming column, when it closes the frame, sees dead cells on its right.
  always_comb begin
    mid_next = lgcs_pkg::next_state(middle, lgcs_pkg::neighbor_count({
      below.older, older, above.older,
      below.middle, above.middle,
      below.current, cur_bit, above.current}));
    cur_next = lgcs_pkg::next_state(cur_bit, lgcs_pkg::neighbor_count({
      below.middle, middle, above.middle,
      below.current, above.current,
      3'b000}));
  end

endmodule

FILE: rtl/lgcs_out_buf.sv
module lgcs_out_buf (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  lgcs_pkg::lgcs_req_t    req,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output lgcs_pkg::lgcs_result_t out_data
);

  lgcs_pkg::lgcs_result_t pend;
  logic                   pend_valid;
  logic                   out_free;

  assign out_free = !out_valid || out_ready;
  // A second result waiting behind the output register holds off new requests.
  assign in_ready = !pend_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (pend_valid && out_free) begin
      out_data   <= pend;
      out_valid  <= 1'b1;
      pend_valid <= 1'b0;
    end else if (take) begin
      if (req.first_valid) begin
        out_data   <= req.first;
        out_valid  <= 1'b1;
        pend       <= req.second;
        pend_valid <= req.second_valid;
      end else begin
        out_data  <= req.second;
        out_valid <= req.second_valid;
      end
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: rtl/lgcs_checker.sv
`include "life_generation_column_stream_assert.svh"

module lgcs_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [lgcs_pkg::COLUMN_BITS-1:0] m_tdata,
  input logic                             m_tlast,
  input logic                             m_tuser
);

  `LGCS_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled result changed")
  `LGCS_ASSERT(a_frame_end_closes_run, clk, rst, m_tvalid && m_tlast |-> m_tuser, "frame end without run end")
  `LGCS_ASSERT(a_stall_blocks_input, clk, rst, m_tvalid && !m_tready |-> !s_tready, "input taken while output stalled")
  `LGCS_ASSERT(a_second_follows, clk, rst, m_tvalid && m_tready && !m_tuser |=> m_tvalid && m_tlast, "second result of last column missing")
  `LGCS_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind life_generation_column_stream lgcs_checker u_lgcs_checker (.*);

FILE: bench/tb_top.sv
module tb_top;

  localparam int COL_W           = lgcs_pkg::COLUMN_BITS;
  localparam int GRID_ROWS       = 64;
  localparam int BIRTH_NEIGHBORS = 3;
  localparam int STAY_NEIGHBORS  = 2;
  localparam int TOTAL_ITEMS     = 1050;
  localparam int DIRECTED_COUNT  = 21;
  localparam int HOLD_OFF_AT     = 300;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_AT        = 700;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int REPORT_LIMIT    = 10;

  typedef lgcs_pkg::lgcs_result_t column_result_t;

  typedef struct packed {
    logic [COL_W-1:0] cells;
    logic             last;
    logic             typed;
    logic [COL_W-1:0] typed_cells;
  } directed_column_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [COL_W-1:0] s_tdata = '0;
  logic             s_tlast = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [COL_W-1:0] m_tdata;
  logic             m_tlast;
  logic             m_tuser;

  // Shadow of the block's column history.
  logic [COL_W-1:0] older_col = '0;
  logic [COL_W-1:0] middle_col = '0;
  logic [1:0]       cols_seen = '0;

  column_result_t   pending_results[$];
  column_result_t   want;
  directed_column_t directed_columns [DIRECTED_COUNT];

  int  error_count = 0;
  int  results_checked = 0;
  int  columns_sent = 0;
  int  frames_sent = 0;
  int  cycle_count = 0;
  logic hold_off_request = 1'b0;

  life_generation_column_stream #(.COLUMN_HEIGHT(GRID_ROWS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [63:0] column_cells
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [63:0] next_cells
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)    // [0] run_last
  );

  always #5 clk = ~clk;

  function automatic int cell_alive(input logic [COL_W-1:0] col, input int row);
    if (row < 0 || row >= GRID_ROWS) begin
      return 0;
    end
    return col[row] ? 1 : 0;
  endfunction

  function automatic logic [COL_W-1:0] next_generation(input logic [COL_W-1:0] left,
                                                        input logic [COL_W-1:0] here,
                                                        input logic [COL_W-1:0] right);
    logic [COL_W-1:0] nxt;
    int               count;
    nxt = '0;
    for (int row = 0; row < GRID_ROWS; row++) begin
      count = 0;
      for (int d = -1; d <= 1; d++) begin
        count += cell_alive(left, row + d) + cell_alive(right, row + d);
        if (d != 0) begin
          count += cell_alive(here, row + d);
        end
      end
      if (count == BIRTH_NEIGHBORS ||
          (cell_alive(here, row) == 1 && count == STAY_NEIGHBORS)) begin
        nxt[row] = 1'b1;
      end
    end
    return nxt;
  endfunction

  // Advances the shadow history by one column and returns how many new columns it releases.
  function automatic int advance_frame(input logic [COL_W-1:0] cells, input logic last,
                                       output column_result_t first,
                                       output column_result_t second);
    column_result_t edge_col;
    int             n;
    n = 0;
    first = '0;
    second = '0;
    if (cols_seen != 0) begin
      first = '{cells: next_generation(older_col, middle_col, cells), frame_end: 1'b0,
                run_last: !last};
      n = 1;
    end
    older_col = middle_col;
    middle_col = cells;
    if (cols_seen < 2) begin
      cols_seen++;
    end
    if (last) begin
      // The rightmost column sees a dead column to its right.
      edge_col = '{cells: next_generation(older_col, middle_col, '0), frame_end: 1'b1,
                   run_last: 1'b1};
      if (n == 0) begin
        first = edge_col;
      end else begin
        second = edge_col;
      end
      n++;
      older_col = '0;
      middle_col = '0;
      cols_seen = '0;
    end
    return n;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 70) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [COL_W-1:0] random_column(input int mode);
    logic [COL_W-1:0] a;
    logic [COL_W-1:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case (mode)
      0: return a;
      1: return a & b & {$urandom, $urandom};
      2: return a | b;
      default: begin
        if ($urandom_range(7, 0) == 0) begin
          return '1;
        end else if ($urandom_range(7, 0) == 0) begin
          return '0;
        end
        return a ^ (b << $urandom_range(63, 0));
      end
    endcase
  endfunction

  task automatic send_column(input logic [COL_W-1:0] cells, input logic last,
                             input logic typed, input logic [COL_W-1:0] typed_cells,
                             input int gap);
    column_result_t first;
    column_result_t second;
    int             n;
    s_tvalid <= 1'b1;
    s_tdata  <= cells;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    n = advance_frame(cells, last, first, second);
    if (typed) begin
      first.cells = typed_cells;
    end
    if (n >= 1) begin
      pending_results.push_back(first);
    end
    if (n == 2) begin
      pending_results.push_back(second);
    end
    columns_sent++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= {$urandom, $urandom};
      s_tlast  <= $urandom_range(1, 0);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("unexpected request: cells=%h frame_end=%b run_last=%b",
                   m_tdata, m_tlast, m_tuser);
        end
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (m_tdata !== want.cells || m_tlast !== want.frame_end ||
            m_tuser !== want.run_last) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("mismatch on result %0d: cells exp %h got %h,",
                     results_checked, want.cells, m_tdata);
            $display("  frame_end exp %b got %b, run_last exp %b got %b",
                     want.frame_end, m_tlast, want.run_last, m_tuser);
          end
        end
      end
    end
  end

  // Output side: random backpressure, plus one long hold so the block fills and stalls.
  initial begin : receiver
    int r;
    @(posedge clk);
    while (rst) begin
      @(posedge clk);
    end
    forever begin
      if (hold_off_request) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_request = 1'b0;
      end else begin
        r = $urandom_range(99, 0);
        if (r < 55) begin
          m_tready <= 1'b1;
          repeat ($urandom_range(20, 1)) @(posedge clk);
        end else if (r < 65) begin
          m_tready <= 1'b1;
          repeat ($urandom_range(120, 50)) @(posedge clk);
        end else if (r < 92) begin
          m_tready <= 1'b0;
          repeat ($urandom_range(3, 1)) @(posedge clk);
        end else begin
          m_tready <= 1'b0;
          repeat ($urandom_range(40, 10)) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int   len;
    int   mode;
    logic steady;
    directed_columns = '{
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE},
      '{64'h0000_0000_0000_0000, 1'b1, 1'b1, 64'h0000_0000_0000_0000},
      '{64'h0000_0000_0000_0001, 1'b1, 1'b1, 64'h0000_0000_0000_0000},
      '{64'h8000_0000_0000_0000, 1'b1, 1'b1, 64'h0000_0000_0000_0000},
      // Blinker across a three-column grid.
      '{64'h0000_0000_0000_0000, 1'b0, 1'b0, 64'h0},
      '{64'h0000_0000_0000_0700, 1'b0, 1'b0, 64'h0},
      '{64'h0000_0000_0000_0000, 1'b1, 1'b0, 64'h0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 64'h0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 64'h0},
      // Top and bottom rows.
      '{64'h8000_0000_0000_0001, 1'b0, 1'b0, 64'h0},
      '{64'hC000_0000_0000_0003, 1'b0, 1'b0, 64'h0},
      '{64'h8000_0000_0000_0001, 1'b1, 1'b0, 64'h0},
      '{64'h5555_5555_5555_5555, 1'b0, 1'b0, 64'h0},
      '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 64'h0},
      '{64'h5555_5555_5555_5555, 1'b0, 1'b0, 64'h0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 64'h0},
      '{64'hC000_0000_0000_0000, 1'b0, 1'b0, 64'h0},
      '{64'hC000_0000_0000_0000, 1'b1, 1'b0, 64'h0}
    };
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      if (directed_columns[i].last) begin
        frames_sent++;
      end
      send_column(directed_columns[i].cells, directed_columns[i].last,
                  directed_columns[i].typed, directed_columns[i].typed_cells, pick_gap());
    end
    wait_for_results();

    while (columns_sent < TOTAL_ITEMS) begin
      len = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(6, 1);
      mode = $urandom_range(3, 0);
      steady = ($urandom_range(3, 0) == 0);
      frames_sent++;
      for (int k = 0; k < len; k++) begin
        if (columns_sent == HOLD_OFF_AT) begin
          hold_off_request = 1'b1;
        end
        if (columns_sent == DRAIN_AT) begin
          wait_for_results();
        end
        send_column(random_column(mode), k == len - 1, 1'b0, '0, steady ? 0 : pick_gap());
      end
    end

    wait_for_results();
    repeat (20) @(posedge clk);

    $display("Covered %0d columns in %0d frames (%0d directed), %0d results checked,",
             columns_sent, frames_sent, DIRECTED_COUNT, results_checked);
    $display("with one %0d-cycle output stall and one full drain mid-stream.",
             HOLD_OFF_CYCLES);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/lgcs_pkg.sv
rtl/lgcs_cell.sv
rtl/lgcs_out_buf.sv
rtl/life_generation_column_stream.sv
rtl/lgcs_checker.sv
bench/tb_top.sv
